FILE: src/rcms_pkg.sv
// rcms_pkg: shared types and constants of the rotated circular minimap sampler
// no dependencies
`timescale 1ns / 1ps

package rcms_pkg;

	localparam int PIX_W     = 8;
	localparam int COEF_W    = 16;
	localparam int CTR_W     = 18;
	localparam int SIZE_W    = 13;
	localparam int SRC_W     = 14;
	localparam int FRAC_BITS = 14;
	localparam int CTR_SHIFT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 18;

	localparam logic signed [COEF_W-1:0] RESET_COS    = 16'sd16384;
	localparam logic signed [COEF_W-1:0] RESET_SIN    = 16'sd0;
	localparam logic [SIZE_W-1:0]        RESET_SIZE   = 13'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS    = 3'd0,
		REG_SIN    = 3'd1,
		REG_CTR_X  = 3'd2,
		REG_CTR_Y  = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] y;
	} pixel_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] rot_cos;
		logic signed [COEF_W-1:0] rot_sin;
		logic [CTR_W-1:0]         ctr_x;
		logic [CTR_W-1:0]         ctr_y;
		logic [SIZE_W-1:0]        width;
		logic [SIZE_W-1:0]        height;
	} cfg_t;

	typedef struct packed {
		logic push;
		logic full;
	} push_ctl_t;

endpackage

FILE: src/rcms_front.sv
// rcms_front: accepts minimap pixels, drops those outside the view or the circle
// depends on rcms_pkg
`timescale 1ns / 1ps

module rcms_front #(
	parameter int VIEW_SIZE   = 256,
	parameter int VIEW_RADIUS = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  rcms_pkg::pixel_t    pixel,
	output rcms_pkg::push_ctl_t push_ctl,
	input  logic                queue_full,
	output rcms_pkg::pixel_t    push_pixel
);

	localparam int OFS_W = ((VIEW_RADIUS > 256) ? $clog2(VIEW_RADIUS) : 8) + 2;
	localparam int SQ_W  = 2 * OFS_W;
	localparam int SUM_W = SQ_W + 1;
	localparam int VS_W  = ($clog2(VIEW_SIZE + 1) > rcms_pkg::PIX_W + 1) ?
		$clog2(VIEW_SIZE + 1) : rcms_pkg::PIX_W + 1;
	localparam logic [SUM_W-1:0] R_SQ = SUM_W'(VIEW_RADIUS * VIEW_RADIUS);

	logic signed [OFS_W-1:0] cx, cy;
	logic signed [SQ_W-1:0]  sq_x, sq_y;
	logic                    view_ok;
	logic [SUM_W-1:0]        dist_sq;
	logic                    in_circle;
	logic                    adv;

	logic                    valid_s1;
	rcms_pkg::pixel_t        pix_s1;
	logic [SQ_W-1:0]         sqx_s1, sqy_s1;

	always_comb begin
		cx        = $signed({{(OFS_W-rcms_pkg::PIX_W){1'b0}}, pixel.x}) - OFS_W'(VIEW_RADIUS);
		cy        = $signed({{(OFS_W-rcms_pkg::PIX_W){1'b0}}, pixel.y}) - OFS_W'(VIEW_RADIUS);
		sq_x      = cx * cx;
		sq_y      = cy * cy;
		view_ok   = (VS_W'(pixel.x) < VS_W'(VIEW_SIZE)) && (VS_W'(pixel.y) < VS_W'(VIEW_SIZE));
		dist_sq   = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		in_circle = dist_sq <= R_SQ;
		adv       = !valid_s1 || !in_circle || !queue_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pixel_valid && view_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pixel;
			sqx_s1 <= sq_x;
			sqy_s1 <= sq_y;
		end
	end

	assign pixel_ready   = adv;
	assign push_ctl.push = valid_s1 && in_circle && !queue_full;
	assign push_ctl.full = queue_full;
	assign push_pixel    = pix_s1;

endmodule

FILE: src/rcms_queue.sv
// rcms_queue: short pixel queue between the classifier and the address datapath
// depends on rcms_pkg
`timescale 1ns / 1ps

module rcms_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rcms_pkg::push_ctl_t push_ctl,
	input  rcms_pkg::pixel_t    push_pixel,
	output logic                full,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rcms_pkg::pixel_t    pop_pixel
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rcms_pkg::pixel_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push      = push_ctl.push;
	assign pop       = pop_valid && pop_ready;
	assign full      = count_q == CNT_W'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_pixel = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_pixel;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !push_ctl.full)
		else $error("queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a beat");

endmodule

FILE: src/rcms_back.sv
// rcms_back: rotates the centred offset, adds the player centre, tests the map bounds
// depends on rcms_pkg
`timescale 1ns / 1ps

module rcms_back #(
	parameter int VIEW_RADIUS = 128
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rcms_pkg::cfg_t                     cfg,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  rcms_pkg::pixel_t                   pop_pixel,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic [rcms_pkg::PIX_W-1:0]         dest_x,
	output logic [rcms_pkg::PIX_W-1:0]         dest_y,
	output logic signed [rcms_pkg::SRC_W-1:0]  source_x,
	output logic signed [rcms_pkg::SRC_W-1:0]  source_y,
	output logic                               use_fill
);

	localparam int OFS_W  = ((VIEW_RADIUS > 256) ? $clog2(VIEW_RADIUS) : 8) + 2;
	localparam int PROD_W = OFS_W + rcms_pkg::COEF_W;
	localparam int CSH_W  = rcms_pkg::CTR_W + rcms_pkg::CTR_SHIFT + 1;
	localparam int T_W    = ((PROD_W + 1 > CSH_W) ? PROD_W + 1 : CSH_W) + 1;
	localparam int SX_W   = T_W - rcms_pkg::FRAC_BITS;
	localparam logic signed [SX_W-1:0] SAT_HI = SX_W'(8191);
	localparam logic signed [SX_W-1:0] SAT_LO = -SX_W'(8192);

	logic                         en;
	logic signed [OFS_W-1:0]      cx, cy;
	logic signed [T_W-1:0]        ctrx_sh, ctry_sh, tx, ty, tbx, tby;
	logic signed [SX_W-1:0]       sx, sy, sx_sat, sy_sat;
	logic                         in_map;

	logic                         valid_s1, valid_s2, valid_s3;
	rcms_pkg::pixel_t             pix_s1, pix_s2, pix_s3;
	logic signed [PROD_W-1:0]     xc_s1, xs_s1, yc_s1, ys_s1;
	logic signed [T_W-1:0]        tx_s2, ty_s2;
	logic signed [SX_W-1:0]       sx_s3, sy_s3;
	logic                         fill_s3;

	assign en        = !valid_s3 || result_ready;
	assign pop_ready = en;

	always_comb begin
		cx = $signed({{(OFS_W-rcms_pkg::PIX_W){1'b0}}, pop_pixel.x}) - OFS_W'(VIEW_RADIUS);
		cy = $signed({{(OFS_W-rcms_pkg::PIX_W){1'b0}}, pop_pixel.y}) - OFS_W'(VIEW_RADIUS);
		ctrx_sh = T_W'($signed({1'b0, cfg.ctr_x, {rcms_pkg::CTR_SHIFT{1'b0}}}));
		ctry_sh = T_W'($signed({1'b0, cfg.ctr_y, {rcms_pkg::CTR_SHIFT{1'b0}}}));
		tx = ctrx_sh + T_W'(xc_s1) - T_W'(ys_s1);
		ty = ctry_sh + T_W'(xs_s1) + T_W'(yc_s1);
		tbx = tx_s2 + (tx_s2[T_W-1] ? T_W'((1 << rcms_pkg::FRAC_BITS) - 1) : T_W'(0));
		tby = ty_s2 + (ty_s2[T_W-1] ? T_W'((1 << rcms_pkg::FRAC_BITS) - 1) : T_W'(0));
		sx = SX_W'(tbx >>> rcms_pkg::FRAC_BITS);
		sy = SX_W'(tby >>> rcms_pkg::FRAC_BITS);
		in_map = !sx[SX_W-1] && !sy[SX_W-1]
			&& (sx[SX_W-2:0] < (SX_W-1)'(cfg.width))
			&& (sy[SX_W-2:0] < (SX_W-1)'(cfg.height));
		sx_sat = (sx > SAT_HI) ? SAT_HI : ((sx < SAT_LO) ? SAT_LO : sx);
		sy_sat = (sy > SAT_HI) ? SAT_HI : ((sy < SAT_LO) ? SAT_LO : sy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pop_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1  <= pop_pixel;
			xc_s1   <= cx * cfg.rot_cos;
			xs_s1   <= cx * cfg.rot_sin;
			yc_s1   <= cy * cfg.rot_cos;
			ys_s1   <= cy * cfg.rot_sin;
			pix_s2  <= pix_s1;
			tx_s2   <= tx;
			ty_s2   <= ty;
			pix_s3  <= pix_s2;
			sx_s3   <= sx_sat;
			sy_s3   <= sy_sat;
			fill_s3 <= !in_map;
		end
	end

	assign result_valid = valid_s3;
	assign dest_x       = pix_s3.x;
	assign dest_y       = pix_s3.y;
	assign source_x     = sx_s3[rcms_pkg::SRC_W-1:0];
	assign source_y     = sy_s3[rcms_pkg::SRC_W-1:0];
	assign use_fill     = fill_s3;

endmodule

FILE: src/rotated_circular_minimap_sampler.sv
// rotated_circular_minimap_sampler: top level, configuration registers and wiring
// depends on rcms_pkg, rcms_front, rcms_queue, rcms_back
// path: front classifier register, queue, then the back product, sum and bound registers
// throughput: one pixel per cycle if not stalled; pixels out of view or circle give no beat
// the figure is set by the four-multiplier rotate stage, one pixel per clock if not stalled
// reset: configuration returns to identity rotation, zero centre and a 4096 by 4096 map
`timescale 1ns / 1ps

module rotated_circular_minimap_sampler #(
	parameter int VIEW_SIZE   = 256,
	parameter int VIEW_RADIUS = 128,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rcms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcms_pkg::CFG_DAT_W-1:0]       cfg_data,
	input  logic                                 pixel_valid,
	output logic                                 pixel_ready,
	input  logic [rcms_pkg::PIX_W-1:0]           pixel_x,
	input  logic [rcms_pkg::PIX_W-1:0]           pixel_y,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic [rcms_pkg::PIX_W-1:0]           dest_x,
	output logic [rcms_pkg::PIX_W-1:0]           dest_y,
	output logic signed [rcms_pkg::SRC_W-1:0]    source_x,
	output logic signed [rcms_pkg::SRC_W-1:0]    source_y,
	output logic                                 use_fill
);

	rcms_pkg::cfg_t      cfg_q;
	rcms_pkg::pixel_t    pixel, push_pixel, pop_pixel;
	rcms_pkg::push_ctl_t push_ctl;
	logic                queue_full, pop_valid, pop_ready;

	assign cfg_ready = 1'b1;
	assign pixel.x   = pixel_x;
	assign pixel.y   = pixel_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_cos <= rcms_pkg::RESET_COS;
			cfg_q.rot_sin <= rcms_pkg::RESET_SIN;
			cfg_q.ctr_x   <= '0;
			cfg_q.ctr_y   <= '0;
			cfg_q.width   <= rcms_pkg::RESET_SIZE;
			cfg_q.height  <= rcms_pkg::RESET_SIZE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rcms_pkg::REG_COS:    cfg_q.rot_cos <= cfg_data[rcms_pkg::COEF_W-1:0];
				rcms_pkg::REG_SIN:    cfg_q.rot_sin <= cfg_data[rcms_pkg::COEF_W-1:0];
				rcms_pkg::REG_CTR_X:  cfg_q.ctr_x   <= cfg_data[rcms_pkg::CTR_W-1:0];
				rcms_pkg::REG_CTR_Y:  cfg_q.ctr_y   <= cfg_data[rcms_pkg::CTR_W-1:0];
				rcms_pkg::REG_WIDTH:  cfg_q.width   <= cfg_data[rcms_pkg::SIZE_W-1:0];
				rcms_pkg::REG_HEIGHT: cfg_q.height  <= cfg_data[rcms_pkg::SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rcms_front #(
		.VIEW_SIZE   (VIEW_SIZE),
		.VIEW_RADIUS (VIEW_RADIUS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.push_ctl    (push_ctl),
		.queue_full  (queue_full),
		.push_pixel  (push_pixel)
	);

	rcms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_ctl   (push_ctl),
		.push_pixel (push_pixel),
		.full       (queue_full),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_pixel  (pop_pixel)
	);

	rcms_back #(
		.VIEW_RADIUS (VIEW_RADIUS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_pixel    (pop_pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.dest_x       (dest_x),
		.dest_y       (dest_y),
		.source_x     (source_x),
		.source_y     (source_y),
		.use_fill     (use_fill)
	);

endmodule

FILE: dv/testbench.sv
// testbench: self-checking bench for rotated_circular_minimap_sampler
// depends on rcms_pkg and the rotated_circular_minimap_sampler rtl
// predicts each source address beat from the register settings and checks it in order
`timescale 1ns / 1ps

module testbench;

	import rcms_pkg::*;

	localparam int VIEW_RADIUS  = 128;
	localparam int PIPE_LATENCY = 5;
	localparam int IDLE_LIMIT   = 1000;
	localparam int PHASE_ITEMS  = 135;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic [PIX_W-1:0]        dx;
		logic [PIX_W-1:0]        dy;
		logic signed [SRC_W-1:0] sx;
		logic signed [SRC_W-1:0] sy;
		logic                    fill;
	} sample_t;

	class source_address_board;
		logic signed [COEF_W-1:0] rot_cos;
		logic signed [COEF_W-1:0] rot_sin;
		logic [CTR_W-1:0]         ctr_x;
		logic [CTR_W-1:0]         ctr_y;
		logic [SIZE_W-1:0]        map_w;
		logic [SIZE_W-1:0]        map_h;
		sample_t                  pending[$];
		int                       mismatches;
		int                       checked;
		int                       fills;

		function new();
			rot_cos    = RESET_COS;
			rot_sin    = RESET_SIN;
			ctr_x      = '0;
			ctr_y      = '0;
			map_w      = RESET_SIZE;
			map_h      = RESET_SIZE;
			mismatches = 0;
			checked    = 0;
			fills      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				REG_COS:    rot_cos = data[COEF_W-1:0];
				REG_SIN:    rot_sin = data[COEF_W-1:0];
				REG_CTR_X:  ctr_x = data[CTR_W-1:0];
				REG_CTR_Y:  ctr_y = data[CTR_W-1:0];
				REG_WIDTH:  map_w = data[SIZE_W-1:0];
				REG_HEIGHT: map_h = data[SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		// centre in q.6 plus rotated offset in q.14, truncated toward zero
		function longint to_map_pixel(longint ctr, longint rot);
			longint t;
			t = (ctr <<< CTR_SHIFT) + rot;
			return t / (longint'(1) <<< FRAC_BITS);
		endfunction

		function logic signed [SRC_W-1:0] clamp_source(longint v);
			if (v > 8191)
				v = 8191;
			if (v < -8192)
				v = -8192;
			return v[SRC_W-1:0];
		endfunction

		function void note_pixel(pixel_t p);
			longint  ox, oy, rx, ry, mx, my;
			sample_t s;
			ox = longint'(p.x) - VIEW_RADIUS;
			oy = longint'(p.y) - VIEW_RADIUS;
			if (ox * ox + oy * oy > VIEW_RADIUS * VIEW_RADIUS)
				return;
			rx = ox * longint'(rot_cos) - oy * longint'(rot_sin);
			ry = ox * longint'(rot_sin) + oy * longint'(rot_cos);
			mx = to_map_pixel(longint'(ctr_x), rx);
			my = to_map_pixel(longint'(ctr_y), ry);
			s.dx   = p.x;
			s.dy   = p.y;
			s.sx   = clamp_source(mx);
			s.sy   = clamp_source(my);
			s.fill = !(mx >= 0 && mx < longint'(map_w) && my >= 0 && my < longint'(map_h));
			pending.push_back(s);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(sample_t got);
			sample_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("beat (%0d,%0d) -> (%0d,%0d) fill %0b with none expected",
					got.dx, got.dy, got.sx, got.sy, got.fill));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.fill)
				fills++;
			if (got.dx !== want.dx)
				report_mismatch($sformatf("dest_x %0d, expected %0d", got.dx, want.dx));
			if (got.dy !== want.dy)
				report_mismatch($sformatf("dest_y %0d, expected %0d", got.dy, want.dy));
			if (got.sx !== want.sx)
				report_mismatch($sformatf("source_x %0d, expected %0d for pixel (%0d,%0d)",
					got.sx, want.sx, want.dx, want.dy));
			if (got.sy !== want.sy)
				report_mismatch($sformatf("source_y %0d, expected %0d for pixel (%0d,%0d)",
					got.sy, want.sy, want.dx, want.dy));
			if (got.fill !== want.fill)
				report_mismatch($sformatf("use_fill %0b, expected %0b for pixel (%0d,%0d)",
					got.fill, want.fill, want.dx, want.dy));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DAT_W-1:0]     cfg_data;
	logic                     pixel_valid;
	logic                     pixel_ready;
	logic [PIX_W-1:0]         pixel_x;
	logic [PIX_W-1:0]         pixel_y;
	logic                     result_valid;
	logic                     result_ready;
	logic [PIX_W-1:0]         dest_x;
	logic [PIX_W-1:0]         dest_y;
	logic signed [SRC_W-1:0]  source_x;
	logic signed [SRC_W-1:0]  source_y;
	logic                     use_fill;

	source_address_board      board;
	logic [2*PIX_W-1:0]       probe_xy [0:15];
	bit                       pixel_gaps;
	bit                       result_stalls;
	int                       quiet_cycles;
	int                       pixels_sent;
	int                       settings_applied;

	rotated_circular_minimap_sampler dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls in bursts of random length
	initial begin : result_side
		int burst;
		burst = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (result_stalls && burst == 0 && $urandom_range(0, 5) == 0)
				burst = $urandom_range(1, 8);
			if (burst > 0) begin
				result_ready = 1'b0;
				burst--;
			end else begin
				result_ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : monitor
		pixel_t  p;
		sample_t got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if (pixel_valid && pixel_ready) begin
				p.x = pixel_x;
				p.y = pixel_y;
				board.note_pixel(p);
			end
			if (result_valid && result_ready) begin
				got.dx   = dest_x;
				got.dy   = dest_y;
				got.sx   = source_x;
				got.sy   = source_y;
				got.fill = use_fill;
				board.check_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (pixel_valid && pixel_ready) ||
			(result_valid && result_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task send_pixel(pixel_t p);
		if (pixel_gaps && $urandom_range(0, 5) == 0) begin
			pixel_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		pixel_valid = 1'b1;
		pixel_x = p.x;
		pixel_y = p.y;
		do @(posedge clk); while (!pixel_ready);
		pixels_sent++;
		@(negedge clk);
	endtask

	// a quarter of the pixels sit on the rim of the circle
	task send_random_pixel();
		pixel_t p;
		int     ox, h, yv;
		if ($urandom_range(0, 3) == 0) begin
			ox = $urandom_range(0, 255) - VIEW_RADIUS;
			h  = int'($floor($sqrt(real'(VIEW_RADIUS * VIEW_RADIUS - ox * ox))));
			yv = ($urandom_range(0, 1) ? VIEW_RADIUS + h : VIEW_RADIUS - h)
				+ $urandom_range(0, 2) - 1;
			if (yv < 0)
				yv = 0;
			if (yv > 255)
				yv = 255;
			p.x = PIX_W'(ox + VIEW_RADIUS);
			p.y = PIX_W'(yv);
		end else begin
			p.x = PIX_W'($urandom_range(0, 255));
			p.y = PIX_W'($urandom_range(0, 255));
		end
		send_pixel(p);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task apply_settings(logic [CFG_DAT_W-1:0] c, logic [CFG_DAT_W-1:0] s,
		logic [CFG_DAT_W-1:0] x, logic [CFG_DAT_W-1:0] y,
		logic [CFG_DAT_W-1:0] w, logic [CFG_DAT_W-1:0] h);
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
		write_reg(REG_CTR_X, x);
		write_reg(REG_CTR_Y, y);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		cfg_valid = 1'b0;
		settings_applied++;
	endtask

	// hold the sender until every expected beat is back, then let the pipe empty
	task drain_pipe();
		pixel_valid = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	initial begin : stimulus
		int ph, i, w, h;
		board            = new();
		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		pixel_valid      = 1'b0;
		pixel_x          = '0;
		pixel_y          = '0;
		pixel_gaps       = 1'b1;
		result_stalls    = 1'b1;
		quiet_cycles     = 0;
		pixels_sent      = 0;
		settings_applied = 0;
		probe_xy = '{16'h0000, 16'hffff, 16'h8080, 16'h8000, 16'h0080, 16'hff80,
			16'h80ff, 16'h8100, 16'hdada, 16'hdbdb, 16'haa55, 16'h55aa,
			16'h7f7f, 16'hff00, 16'h00ff, 16'h0180};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corners, centre, rim points just inside and outside, under reset settings
		for (i = 0; i < 16; i++)
			send_pixel(pixel_t'(probe_xy[i]));
		drain_pipe();

		apply_settings(CFG_DAT_W'(-16384), CFG_DAT_W'(16384), CFG_DAT_W'(262143),
			CFG_DAT_W'(262143), CFG_DAT_W'(1), CFG_DAT_W'(1));
		for (i = 0; i < 60; i++)
			send_random_pixel();
		drain_pipe();

		apply_settings(CFG_DAT_W'(16384), CFG_DAT_W'(-16384), CFG_DAT_W'(32),
			CFG_DAT_W'(32), CFG_DAT_W'(4096), CFG_DAT_W'(4096));
		for (i = 0; i < 60; i++)
			send_random_pixel();
		drain_pipe();

		// coefficients beyond one, upper data bits set, zero width
		apply_settings(18'h08000, 18'h37fff, CFG_DAT_W'(131072),
			CFG_DAT_W'(0), CFG_DAT_W'(0), CFG_DAT_W'(8191));
		for (i = 0; i < 60; i++)
			send_random_pixel();
		drain_pipe();

		// writes to unused indexes must not disturb anything
		write_reg(REG_SPARE_LO, 18'h3ffff);
		write_reg(REG_SPARE_HI, 18'h00000);
		apply_settings(CFG_DAT_W'(0), CFG_DAT_W'(16384), CFG_DAT_W'(2048 * 64),
			CFG_DAT_W'(2048 * 64), CFG_DAT_W'(4096), CFG_DAT_W'(4096));
		write_reg(REG_SPARE_HI, 18'h3ffff);
		cfg_valid = 1'b0;
		for (i = 0; i < 60; i++)
			send_random_pixel();
		drain_pipe();

		for (ph = 0; ph < 9; ph++) begin
			if (ph % 3 == 2) begin
				w = $urandom_range(0, 8191);
				h = $urandom_range(0, 8191);
				apply_settings(CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
					CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), CFG_DAT_W'(w), CFG_DAT_W'(h));
			end else begin
				w = $urandom_range(1, 4096);
				h = $urandom_range(1, 4096);
				apply_settings(CFG_DAT_W'(int'($urandom_range(0, 32768)) - 16384),
					CFG_DAT_W'(int'($urandom_range(0, 32768)) - 16384),
					CFG_DAT_W'($urandom_range(0, (w * 64 > 262143) ? 262143 : w * 64)),
					CFG_DAT_W'($urandom_range(0, (h * 64 > 262143) ? 262143 : h * 64)),
					CFG_DAT_W'(w), CFG_DAT_W'(h));
			end
			pixel_gaps    = (ph != 8) && ($urandom_range(0, 3) != 0);
			result_stalls = (ph != 8) && ($urandom_range(0, 3) != 0);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if (i == 60 && (ph == 0 || $urandom_range(0, 3) == 0))
					drain_pipe();
				send_random_pixel();
			end
			drain_pipe();
		end

		pixel_valid = 1'b0;
		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
		if (board.pending.size() != 0)
			board.report_mismatch($sformatf("%0d expected beats never arrived",
				board.pending.size()));
		$display("covered %0d pixels and %0d address beats (%0d fill) under %0d register settings",
			pixels_sent, board.checked, board.fills, settings_applied);
		$display("%0d mismatches", board.mismatches);
		if (board.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
